FILE: rtl/core/kiss_pkg.sv
// shared types and constants for the kiss bounded generator
package kiss_pkg;
  localparam logic [31:0] XS_INIT = 32'h5eed5eed;
  localparam logic [15:0] MWC_Z_MUL = 16'd36969;
  localparam logic [15:0] MWC_W_MUL = 16'd18000;
  localparam logic [31:0] LCG_MUL = 32'd69069;
  localparam logic [31:0] LCG_ADD = 32'd1234567;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_THRESH,
    ST_DRAW,
    ST_CHECK,
    ST_MOD,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    logic        trivial;
    logic [31:0] bound;
  } job_t;
endpackage

FILE: rtl/core/kiss_stream_if.sv
// valid/ready channel carrying one 32-bit field
interface kiss_stream_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/kiss_front.sv
// front end: accepts requests, classifies them, and queues them
module kiss_front (
  input  logic       clk_i,
  input  logic       rst_ni,
  kiss_stream_if.sink req,
  output kiss_pkg::job_t job_o,
  output logic       job_valid_o,
  input  logic       job_pop_i
);
  import kiss_pkg::*;
  job_t       q_mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign req.ready   = (cnt_q != 2'd2);
  assign push        = req.valid && req.ready;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= '{trivial: (req.data < 32'd2), bound: req.data};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (job_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(job_pop_i);
    end
  end
endmodule

FILE: rtl/core/kiss_back.sv
// back end: generator state, threshold, rejection loop and serial modulo
module kiss_back (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [31:0] seed_i,
  input  kiss_pkg::job_t job_i,
  input  logic        job_valid_i,
  output logic        job_pop_o,
  kiss_stream_if.source rsp
);
  import kiss_pkg::*;
  back_state_e state_q, state_d;
  logic [31:0] z_q, w_q, c_q, x_q;
  logic [31:0] bound_q, thr_q, word_q, rem_q, dvd_q;
  logic [5:0]  cnt_q;
  logic [31:0] val_q;
  logic [31:0] z_n, w_n, c_n, x_n, x1, x2, mix;
  logic [32:0] trial, rem_sh;

  // kiss step
  always_comb begin
    z_n = MWC_Z_MUL * z_q[15:0] + {16'd0, z_q[31:16]};
    w_n = MWC_W_MUL * w_q[15:0] + {16'd0, w_q[31:16]};
    c_n = LCG_MUL * c_q + LCG_ADD;
    x1  = x_q ^ (x_q << 13);
    x2  = x1 ^ (x1 >> 17);
    x_n = x2 ^ (x2 << 5);
    mix = (((z_n << 16) + w_n) ^ c_n) + x_n;
  end

  // restoring division step, one bit per cycle
  assign rem_sh = {rem_q, dvd_q[31]};
  assign trial  = rem_sh - {1'b0, bound_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (job_valid_i) state_d = job_i.trivial ? ST_OUT : ST_THRESH;
      ST_THRESH: if (cnt_q == 6'd32) state_d = ST_DRAW;
      ST_DRAW:   state_d = ST_CHECK;
      ST_CHECK:  state_d = (word_q < thr_q) ? ST_DRAW : ST_MOD;
      ST_MOD:    if (cnt_q == 6'd31) state_d = ST_OUT;
      ST_OUT:    if (rsp.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o = (state_q == ST_IDLE) && job_valid_i;
    rsp.valid = (state_q == ST_OUT);
    rsp.data  = val_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      z_q <= 32'd1;
      w_q <= 32'd0;
      c_q <= 32'd0;
      x_q <= XS_INIT;
      cnt_q <= 6'd0;
    end else begin
      state_q <= state_d;
      if (seed_we_i) begin
        z_q <= seed_i ^ 32'd1;
        w_q <= seed_i;
        c_q <= seed_i;
        x_q <= XS_INIT;
      end else if (state_q == ST_DRAW) begin
        z_q <= z_n;
        w_q <= w_n;
        c_q <= c_n;
        x_q <= x_n;
      end
      if (state_q == ST_THRESH || state_q == ST_MOD) cnt_q <= cnt_q + 6'd1;
      else cnt_q <= 6'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        bound_q <= job_i.bound;
        val_q   <= 32'd0;
        // 2^32 mod b: one leading 1 then 32 zeros
        rem_q   <= 32'd1;
        dvd_q   <= 32'd0;
      end
      ST_THRESH: begin
        if (cnt_q == 6'd32) thr_q <= rem_q;
        else rem_q <= trial[32] ? rem_sh[31:0] : trial[31:0];
      end
      ST_DRAW: word_q <= mix;
      ST_CHECK: begin
        rem_q <= 32'd0;
        dvd_q <= word_q;
      end
      ST_MOD: begin
        rem_q <= trial[32] ? rem_sh[31:0] : trial[31:0];
        dvd_q <= dvd_q << 1;
        if (cnt_q == 6'd31) val_q <= trial[32] ? rem_sh[31:0] : trial[31:0];
      end
      default: ;
    endcase
  end
endmodule

FILE: rtl/core/kiss_uniform_bounded_rng.sv
// top level of the kiss bounded uniform random generator
//  channel | dir | payload | handshake
//  req     | in  | bound   | valid/ready
//  rsp     | out | value   | valid/ready
//  seed    | in  | seed    | write enable
// a bound below 2 answers without drawing
// otherwise the threshold divider runs, then draws repeat while a word is below the
// threshold, then the final modulo runs; the divider yields one bit per cycle
// reset loads the state as if seed 0 were written
// a two-entry request queue lets the front accept while the back works or stalls
module kiss_uniform_bounded_rng (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [31:0] seed_i,
  kiss_stream_if.sink   req,
  kiss_stream_if.source rsp
);
  import kiss_pkg::*;
  job_t job;
  logic job_valid, job_pop;

  // front classifies and queues requests
  kiss_front u_front (
    .clk_i, .rst_ni, .req,
    .job_o(job), .job_valid_o(job_valid), .job_pop_i(job_pop)
  );

  // back draws words and reduces
  kiss_back u_back (
    .clk_i, .rst_ni, .seed_we_i, .seed_i,
    .job_i(job), .job_valid_i(job_valid), .job_pop_o(job_pop), .rsp
  );

`ifndef SYNTHESIS
  // pending response never changes while stalled
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data)) else $error("rsp hold");
  // the back only pops a request from a non-empty queue
  a_pop_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> job_valid) else $error("pop of empty queue");
`endif
endmodule
